// ===== rtl/core/ffsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsr_pkg
// Shared types, constants and the header pattern of the status frame receiver.
// ----------------------------------------------------------------------------
package ffsr_pkg;

    localparam int FRAME_LEN   = 38;
    localparam int SUM_LEN     = 35;
    localparam int HDR_LEN     = 8;
    localparam int TIME_FIRST  = 8;
    localparam int WORD_FIRST  = 11;
    localparam int NUM_TIME    = 3;
    localparam int NUM_WORDS   = 6;
    localparam int NUM_VBYTES  = NUM_WORDS * 4;
    localparam int POS_W       = 6;
    localparam int VIDX_W      = 5;
    localparam int RESULT_BITS = 2 + 3 * 8 + NUM_WORDS * 32;
    localparam int TDATA_W     = ((RESULT_BITS + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_W - RESULT_BITS;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_HEADER   = 2'd1,
        STATUS_CHECKSUM = 2'd2
    } status_t;

    // lowest field in the lowest bits, same layout as the output word
    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic [31:0]      voltage_bits;
        logic [31:0]      current_bits;
        logic [31:0]      percent_bits;
        logic [31:0]      used_bits;
        logic [31:0]      capacity_bits;
        logic [31:0]      total_bits;
        logic [7:0]       seconds;
        logic [7:0]       minutes;
        logic [7:0]       hours;
        status_t          frame_status;
    } result_t;

    typedef struct packed {
        logic step;
        logic last;
    } step_ctrl_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h24; // '$'
            3'd1:    c = 8'h41; // 'A'
            3'd2:    c = 8'h55; // 'U'
            3'd3:    c = 8'h56; // 'V'
            3'd4:    c = 8'h32; // '2'
            default: c = 8'h30; // '0'
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fixed_frame_status_receiver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result path: the last byte of a frame passes the input register, then loads the result
// register once that has room; m_tvalid comes straight from the result register
// throughput: one byte per cycle sustained; only the last byte of a frame waits on the
// result register, everything else streams through the input register and parser
// reset: rst_n async low clears the byte count, checks and valid flags; captured fields
// are not reset and are always rewritten before a frame result uses them
// ----------------------------------------------------------------------------
// fixed_frame_status_receiver_unit
// Cuts received bytes into fixed 38-byte status frames and emits one checked
// result word per frame.
// ----------------------------------------------------------------------------
module fixed_frame_status_receiver_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,   // rx_byte
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // frame_status, hours, minutes, seconds, total_bits, capacity_bits,
    // used_bits, percent_bits, current_bits, voltage_bits, zero pad
    output logic [ffsr_pkg::TDATA_W-1:0] m_tdata
);
    import ffsr_pkg::*;

    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       last;
    logic       room;
    result_t    result;
    step_ctrl_t ctrl;

    // the last byte of a frame only moves when the result register is free
    assign ctrl.step = byte_valid && (!last || room);
    assign ctrl.last = last;

    ffsr_input_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .drain      (ctrl.step),
        .byte_valid (byte_valid),
        .rx_byte    (rx_byte)
    );

    ffsr_frame_parser u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (ctrl.step),
        .rx_byte (rx_byte),
        .last    (last),
        .result  (result)
    );

    ffsr_output_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .result   (result),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && ctrl.last |=> m_tvalid)
        else $error("frame result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !(ctrl.step && ctrl.last))
        else $error("pending result overwritten");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !ctrl.step |-> !s_tready)
        else $error("input taken while stage blocked");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ffsr_input_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsr_input_stage
// Input register for received bytes, refilled in the cycle it drains.
// ----------------------------------------------------------------------------
module ffsr_input_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // rx_byte
    input  wire logic       drain,
    output logic            byte_valid,
    output logic [7:0]      rx_byte
);
    import ffsr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready   = !valid_reg || drain;
    assign valid_next = (valid_reg && !drain) || s_tvalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ffsr_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsr_frame_parser
// Byte counter, header and checksum checks and field capture for one frame.
// ----------------------------------------------------------------------------
module ffsr_frame_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   rx_byte,
    output logic              last,
    output ffsr_pkg::result_t result
);
    import ffsr_pkg::*;

    pos_t       pos_reg;
    pos_t       pos_next;
    logic       header_good_reg;
    logic       header_good_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       checksum_good_reg;
    logic       checksum_good_next;

    logic [7:0] time_reg [NUM_TIME];
    logic [7:0] vbyte_reg [NUM_VBYTES];

    logic              in_hdr;
    logic              in_time;
    logic              in_words;
    logic              at_sum;
    logic [POS_W-1:0]  voff;
    logic [VIDX_W-1:0] vidx;
    logic [1:0]        tidx;

    assign in_hdr   = pos_reg < POS_W'(HDR_LEN);
    assign in_time  = !in_hdr && (pos_reg < POS_W'(WORD_FIRST));
    assign in_words = (pos_reg >= POS_W'(WORD_FIRST)) && (pos_reg < POS_W'(SUM_LEN));
    assign at_sum   = pos_reg == POS_W'(SUM_LEN);
    assign last     = pos_reg >= POS_W'(FRAME_LEN - 1);
    assign voff     = pos_reg - POS_W'(WORD_FIRST);
    assign vidx     = voff[VIDX_W-1:0];
    assign tidx     = 2'(pos_reg - POS_W'(TIME_FIRST));

    always_comb
    begin
        pos_next           = pos_reg + POS_W'(1);
        header_good_next   = header_good_reg;
        sum_next           = sum_reg;
        checksum_good_next = checksum_good_reg;
        if (in_hdr && (rx_byte != hdr_char(pos_reg[2:0])))
        begin
            header_good_next = 1'b0;
        end
        if (at_sum)
        begin
            checksum_good_next = rx_byte == 8'(8'd0 - sum_reg);
        end
        if (pos_reg < POS_W'(SUM_LEN))
        begin
            sum_next = sum_reg + rx_byte;
        end
        if (last)
        begin
            pos_next           = '0;
            header_good_next   = 1'b1;
            sum_next           = '0;
            checksum_good_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            header_good_reg   <= 1'b1;
            sum_reg           <= '0;
            checksum_good_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg           <= pos_next;
            header_good_reg   <= header_good_next;
            sum_reg           <= sum_next;
            checksum_good_reg <= checksum_good_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_time)
        begin
            time_reg[tidx] <= rx_byte;
        end
        if (step && in_words)
        begin
            vbyte_reg[vidx] <= rx_byte;
        end
    end

    // header fault wins over checksum fault
    always_comb
    begin
        result.pad           = '0;
        result.frame_status  = !header_good_reg   ? STATUS_HEADER :
                               !checksum_good_reg ? STATUS_CHECKSUM : STATUS_OK;
        result.hours         = time_reg[0];
        result.minutes       = time_reg[1];
        result.seconds       = time_reg[2];
        result.total_bits    = {vbyte_reg[3],  vbyte_reg[2],  vbyte_reg[1],  vbyte_reg[0]};
        result.capacity_bits = {vbyte_reg[7],  vbyte_reg[6],  vbyte_reg[5],  vbyte_reg[4]};
        result.used_bits     = {vbyte_reg[11], vbyte_reg[10], vbyte_reg[9],  vbyte_reg[8]};
        result.percent_bits  = {vbyte_reg[15], vbyte_reg[14], vbyte_reg[13], vbyte_reg[12]};
        result.current_bits  = {vbyte_reg[19], vbyte_reg[18], vbyte_reg[17], vbyte_reg[16]};
        result.voltage_bits  = {vbyte_reg[23], vbyte_reg[22], vbyte_reg[21], vbyte_reg[20]};
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(FRAME_LEN))
        else $error("frame position out of range");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> (pos_reg == '0) && header_good_reg && (sum_reg == '0))
        else $error("frame state not restarted after last byte");

    a_hdr_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) |-> header_good_reg && !checksum_good_reg)
        else $error("stale check flags at frame start");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ffsr_output_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsr_output_stage
// Result register holding one finished frame word until it is taken.
// ----------------------------------------------------------------------------
module ffsr_output_stage (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ffsr_pkg::step_ctrl_t            ctrl,
    input  wire ffsr_pkg::result_t               result,
    output logic                                 room,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // frame_status, hours, minutes, seconds, total_bits, capacity_bits,
    // used_bits, percent_bits, current_bits, voltage_bits, zero pad
    output logic [ffsr_pkg::TDATA_W-1:0]         m_tdata
);
    import ffsr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    load;
    result_t data_reg;

    assign room       = !valid_reg || m_tready;
    assign load       = ctrl.step && ctrl.last;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status frame receiver testbench
// Streams 38-byte status frames into the receiver, with random gaps on the
// byte side and random stalls on the result side. A first set of hand-built
// frames covers field extremes, header faults, checksum faults and both at
// once. Random frames follow: mostly well-formed with random content, some
// with a broken header or checksum, some pure noise. Every result word is
// compared field by field with an in-order queue of predicted frames.
// ----------------------------------------------------------------------------
module testbench;

    import ffsr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_FRAMES = 30;
    localparam int NUM_CASES     = 6;
    localparam int DRAIN_CYCLES  = 10;

    // frame header, first character in the low byte
    localparam logic [63:0] HDR_BYTES = 64'h3030_3032_5655_4124;

    typedef logic [7:0] frame_bytes_t [FRAME_LEN];

    typedef struct {
        logic [7:0]   hours;
        logic [7:0]   minutes;
        logic [7:0]   seconds;
        logic [191:0] words;     // word k at bits 32k up
        int           hdr_pos;   // HDR_LEN leaves the header intact
        logic [7:0]   hdr_xor;
        logic [7:0]   sum_xor;
        logic [15:0]  tail;
        status_t      status;
    } frame_case_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;

    int      mismatch_count;
    int      cycle_count;
    bit      src_steady;
    result_t pending_frames [$];

    // receiver state as the frame parser sees it
    pos_t        rx_pos;
    bit          rx_hdr_ok;
    logic [7:0]  rx_sum;
    bit          rx_sum_ok;
    logic [7:0]  rx_time [NUM_TIME];
    logic [31:0] rx_word [NUM_WORDS];

    frame_case_t frame_cases [NUM_CASES] = '{
        '{8'h00, 8'h00, 8'h00, {6{32'h0000_0000}}, HDR_LEN, 8'h00, 8'h00, 16'h0000,
          STATUS_OK},
        '{8'hFF, 8'hFF, 8'hFF, {6{32'hFFFF_FFFF}}, HDR_LEN, 8'h00, 8'h00, 16'hFFFF,
          STATUS_OK},
        '{8'd23, 8'd59, 8'd59,
          {32'h8000_0001, 32'hDDEE_FF00, 32'h99AA_BBCC, 32'h5566_7788, 32'h1122_3344,
           32'h0102_0304}, 0, 8'h01, 8'h00, 16'hA55A, STATUS_HEADER},
        '{8'h80, 8'h01, 8'h7F, {6{32'h7F80_0000}}, 7, 8'h80, 8'h01, 16'h0102,
          STATUS_HEADER},
        '{8'h12, 8'h34, 8'h56, {6{32'h3F80_0000}}, HDR_LEN, 8'h00, 8'h01, 16'h0000,
          STATUS_CHECKSUM},
        '{8'h00, 8'hFF, 8'h00,
          {32'hFFFF_FFFF, 32'h0000_0000, 32'hC2C8_0000, 32'h4120_0000, 32'h0000_0001,
           32'h8000_0000}, HDR_LEN, 8'h00, 8'h80, 16'hFF00, STATUS_CHECKSUM}
    };

    fixed_frame_status_receiver_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void restart_frame();
        rx_pos    = '0;
        rx_hdr_ok = 1'b1;
        rx_sum    = 8'h00;
        rx_sum_ok = 1'b0;
    endfunction

    // advances the frame parser by one byte, returns 1 with the frame result on byte 37
    function automatic bit track_frame_byte(input logic [7:0] b, output result_t r);
        int p;
        int off;
        p = int'(rx_pos);
        r = '0;
        if (p < HDR_LEN)
        begin
            if (b != HDR_BYTES[8*p +: 8])
                rx_hdr_ok = 1'b0;
        end
        else if (p < WORD_FIRST)
            rx_time[p - TIME_FIRST] = b;
        else if (p < SUM_LEN)
        begin
            off = p - WORD_FIRST;
            rx_word[off / 4][8*(off % 4) +: 8] = b;
        end
        else if (p == SUM_LEN)
            rx_sum_ok = (b == 8'(8'h00 - rx_sum));
        if (p < SUM_LEN)
            rx_sum = 8'(rx_sum + b);
        if (p + 1 < FRAME_LEN)
        begin
            rx_pos = pos_t'(p + 1);
            return 1'b0;
        end
        // a header fault wins over a checksum fault
        r.frame_status  = !rx_hdr_ok ? STATUS_HEADER : (!rx_sum_ok ? STATUS_CHECKSUM : STATUS_OK);
        r.hours         = rx_time[0];
        r.minutes       = rx_time[1];
        r.seconds       = rx_time[2];
        r.total_bits    = rx_word[0];
        r.capacity_bits = rx_word[1];
        r.used_bits     = rx_word[2];
        r.percent_bits  = rx_word[3];
        r.current_bits  = rx_word[4];
        r.voltage_bits  = rx_word[5];
        restart_frame();
        return 1'b1;
    endfunction

    task automatic fill_frame(input logic [7:0] h, input logic [7:0] m, input logic [7:0] s,
                              input logic [191:0] words, input int hdr_pos,
                              input logic [7:0] hdr_xor, input logic [7:0] sum_xor,
                              input logic [15:0] tail, output frame_bytes_t fb);
        logic [7:0] sum;
        for (int k = 0; k < HDR_LEN; k++)
            fb[k] = HDR_BYTES[8*k +: 8];
        if (hdr_pos < HDR_LEN)
            fb[hdr_pos] = fb[hdr_pos] ^ hdr_xor;
        fb[TIME_FIRST]     = h;
        fb[TIME_FIRST + 1] = m;
        fb[TIME_FIRST + 2] = s;
        for (int k = 0; k < NUM_VBYTES; k++)
            fb[WORD_FIRST + k] = words[8*k +: 8];
        sum = 8'h00;
        for (int k = 0; k < SUM_LEN; k++)
            sum = 8'(sum + fb[k]);
        fb[SUM_LEN]     = 8'(8'h00 - sum) ^ sum_xor;
        fb[SUM_LEN + 1] = tail[7:0];
        fb[SUM_LEN + 2] = tail[15:8];
    endtask

    task automatic send_byte(input logic [7:0] b, output bit done, output result_t r);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        done = track_frame_byte(b, r);
    endtask

    task automatic send_frame(input frame_bytes_t fb, input bit use_typed, input result_t typed);
        bit      done;
        result_t r;
        src_steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            send_byte(fb[k], done, r);
            if (done)
                pending_frames.push_back(use_typed ? typed : r);
        end
    endtask

    task automatic random_frame(output frame_bytes_t fb);
        logic [191:0] words;
        int           kind;
        int           hdr_pos;
        logic [7:0]   hdr_xor;
        logic [7:0]   sum_xor;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            // noise: the parser still takes it as one frame
            for (int k = 0; k < FRAME_LEN; k++)
                fb[k] = 8'($urandom);
        end
        else
        begin
            for (int w = 0; w < NUM_WORDS; w++)
                words[32*w +: 32] = $urandom;
            hdr_pos = HDR_LEN;
            hdr_xor = 8'h00;
            sum_xor = 8'h00;
            if ($urandom_range(0, 99) < 15)
            begin
                hdr_pos = $urandom_range(0, HDR_LEN - 1);
                hdr_xor = 8'($urandom_range(1, 255));
            end
            if ($urandom_range(0, 99) < 20)
                sum_xor = 8'($urandom_range(1, 255));
            fill_frame(8'($urandom), 8'($urandom), 8'($urandom), words, hdr_pos, hdr_xor,
                       sum_xor, 16'($urandom), fb);
        end
    endtask

    // result side: random stall before each word, with steady stretches
    initial
    begin
        int stall;
        bit steady;
        m_tready = 1'b0;
        steady   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_frames.size() == 0)
                report("unexpected result word", 32'(got.frame_status), 32'h0);
            else
            begin
                want = pending_frames.pop_front();
                if (got.frame_status !== want.frame_status)
                    report("frame_status", 32'(got.frame_status), 32'(want.frame_status));
                if (got.hours !== want.hours)
                    report("hours", 32'(got.hours), 32'(want.hours));
                if (got.minutes !== want.minutes)
                    report("minutes", 32'(got.minutes), 32'(want.minutes));
                if (got.seconds !== want.seconds)
                    report("seconds", 32'(got.seconds), 32'(want.seconds));
                if (got.total_bits !== want.total_bits)
                    report("total_bits", got.total_bits, want.total_bits);
                if (got.capacity_bits !== want.capacity_bits)
                    report("capacity_bits", got.capacity_bits, want.capacity_bits);
                if (got.used_bits !== want.used_bits)
                    report("used_bits", got.used_bits, want.used_bits);
                if (got.percent_bits !== want.percent_bits)
                    report("percent_bits", got.percent_bits, want.percent_bits);
                if (got.current_bits !== want.current_bits)
                    report("current_bits", got.current_bits, want.current_bits);
                if (got.voltage_bits !== want.voltage_bits)
                    report("voltage_bits", got.voltage_bits, want.voltage_bits);
                if (got.pad !== '0)
                    report("pad", 32'(got.pad), 32'h0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        frame_bytes_t fb;
        result_t      typed;
        frame_case_t  c;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        mismatch_count = 0;
        cycle_count    = 0;
        src_steady     = 1'b0;
        restart_frame();
        for (int k = 0; k < NUM_TIME; k++)
            rx_time[k] = 8'h00;
        for (int k = 0; k < NUM_WORDS; k++)
            rx_word[k] = 32'h0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hand-built frames, result read straight off the table
        for (int i = 0; i < NUM_CASES; i++)
        begin
            c = frame_cases[i];
            fill_frame(c.hours, c.minutes, c.seconds, c.words, c.hdr_pos, c.hdr_xor,
                       c.sum_xor, c.tail, fb);
            typed               = '0;
            typed.frame_status  = c.status;
            typed.hours         = c.hours;
            typed.minutes       = c.minutes;
            typed.seconds       = c.seconds;
            typed.total_bits    = c.words[31:0];
            typed.capacity_bits = c.words[63:32];
            typed.used_bits     = c.words[95:64];
            typed.percent_bits  = c.words[127:96];
            typed.current_bits  = c.words[159:128];
            typed.voltage_bits  = c.words[191:160];
            send_frame(fb, 1'b1, typed);
        end

        typed = '0;
        repeat (RANDOM_FRAMES)
        begin
            random_frame(fb);
            send_frame(fb, 1'b0, typed);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
